/* rtl/core/button_click_event_detector_assert.svh */
// Assertion macros used by the checker module of the key click detector.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BCED_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset; seq carries its own |-> or |=>.
`define BCED_ASSERT_IMPLY(label, clk, rst_n, seq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) seq) else $error(msg);

`endif

/* rtl/core/bced_pkg.sv */
// Package with the state, event and register index codes of the key click detector.
`timescale 1ns / 1ps

package bced_pkg;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_HELD       = 3'd1,
        ST_WAIT       = 3'd2,
        ST_HELD_AGAIN = 3'd3,
        ST_LONG_HOLD  = 3'd5
    } t_state;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_DOWN       = 3'd1,
        EV_UP         = 3'd2,
        EV_SINGLE     = 3'd3,
        EV_DOUBLE     = 3'd4,
        EV_LONG_START = 3'd5,
        EV_LONG_HOLD  = 3'd6
    } t_event;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_DETECT_MODE  = 3'd0;
    localparam t_cfg_index CFG_ACTIVE_LEVEL = 3'd1;
    localparam t_cfg_index CFG_WINDOW_DELTA = 3'd2;
    localparam t_cfg_index CFG_FILTER_TICKS = 3'd3;
    localparam t_cfg_index CFG_SHORT_TICKS  = 3'd4;
    localparam t_cfg_index CFG_LONG_TICKS   = 3'd5;

    localparam int          WINDOW_RESET  = 100;
    localparam logic [3:0]  FILTER_RESET  = 4'd3;
    localparam logic [9:0]  SHORT_RESET   = 10'd60;
    localparam logic [9:0]  LONG_RESET    = 10'd200;
    localparam logic [3:0]  COUNT_MAX     = 4'd15;
    localparam int          TIMING_BITS   = 10;

endpackage

/* rtl/core/button_click_event_detector.sv */
// Top level of the key click detector: debouncing, pressed decode and click state machine.
`timescale 1ns / 1ps

// Usage
// The block takes one raw key sample per transaction on the input channel
// (i_in_valid, o_in_ready, i_raw_level) and returns one result per sample on
// the output channel (o_out_valid, i_out_ready, o_event_code, o_click_count).
// The event code is sticky during a press sequence, so each result repeats the
// last event until a new one is raised; in idle it reads none. The click count
// is the number of presses in the current run. An accepted sample waits in the
// input register until the computation stage advances and loads its result.
// Throughput is one sample per cycle without a receiver stall, set by the single
// register-to-register pass that debounces, decodes and advances the machine.
// When the receiver stalls, the result register holds its value and the input
// register fills; the input channel then stops accepting until the result is
// taken. Configuration is written through i_cfg_valid, i_cfg_index and
// i_cfg_data, always ready, and should be written only while the block is idle.
// Reset (synchronous, active low) empties both registers, returns the state
// machine to idle with zero counts and restores every register default.
module button_click_event_detector #(
    parameter int SAMPLE_BITS = 12,
    parameter int TICK_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_raw_level,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output bced_pkg::t_event       o_event_code,
    output logic [3:0]             o_click_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  bced_pkg::t_cfg_index   i_cfg_index,
    input  logic [((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10)-1:0] i_cfg_data
);
    import bced_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [TICK_BITS-1:0]   TICK_MAX   = {TICK_BITS{1'b1}};

    // Configuration registers.
    logic                   r_detect_mode;
    logic [SAMPLE_BITS-1:0] r_active_level;
    logic [SAMPLE_BITS-1:0] r_window_delta;
    logic [3:0]             r_filter_ticks;
    logic [9:0]             r_short_ticks;
    logic [9:0]             r_long_ticks;

    // Detector state.
    t_state                 r_state;
    t_state                 n_state;
    logic [TICK_BITS-1:0]   r_tick;
    logic [TICK_BITS-1:0]   n_tick;
    logic [3:0]             r_repeat;
    logic [3:0]             n_repeat;
    logic [SAMPLE_BITS-1:0] r_deb_level;
    logic [SAMPLE_BITS-1:0] n_deb_level;
    logic [3:0]             r_filter_cnt;
    logic [3:0]             n_filter_cnt;
    t_event                 r_last_event;
    t_event                 n_last_event;

    // Input and result registers.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_level;
    logic                   r_out_valid;
    t_event                 r_out_event;
    logic [3:0]             r_out_count;

    logic                   in_take;
    logic                   advance;

    logic [SAMPLE_BITS-1:0] win_lo;
    logic [SAMPLE_BITS:0]   win_sum;
    logic [SAMPLE_BITS-1:0] win_hi;
    logic                   sample_in_win;
    logic                   deb_in_win;
    logic                   new_in_win;
    logic                   differs;
    logic [3:0]             filter_inc;
    logic                   pressed;
    logic [TICK_BITS-1:0]   tick_step;
    logic                   over_long;
    logic                   over_short;
    logic                   under_short;

    // The computation stage moves on when the input register holds a sample and
    // the result register is free or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_mode  <= 1'b0;
            r_active_level <= '0;
            r_window_delta <= SAMPLE_BITS'(WINDOW_RESET);
            r_filter_ticks <= FILTER_RESET;
            r_short_ticks  <= SHORT_RESET;
            r_long_ticks   <= LONG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DETECT_MODE:  r_detect_mode  <= i_cfg_data[0];
                CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_WINDOW_DELTA: r_window_delta <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_FILTER_TICKS: r_filter_ticks <= i_cfg_data[3:0];
                CFG_SHORT_TICKS:  r_short_ticks  <= i_cfg_data[TIMING_BITS-1:0];
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data[TIMING_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Analog window, clamped at zero and at full scale rather than wrapping.
    assign win_lo  = (r_active_level > r_window_delta) ? (r_active_level - r_window_delta) : '0;
    assign win_sum = {1'b0, r_active_level} + {1'b0, r_window_delta};
    assign win_hi  = win_sum[SAMPLE_BITS] ? SAMPLE_MAX : win_sum[SAMPLE_BITS-1:0];

    assign sample_in_win = (r_in_level >= win_lo) && (r_in_level <= win_hi);
    assign deb_in_win    = (r_deb_level >= win_lo) && (r_deb_level <= win_hi);

    // In analog mode a sample only counts as different when it lies on the
    // other side of the window from the debounced level.
    assign differs    = r_detect_mode ? (sample_in_win != deb_in_win)
                                      : (r_in_level != r_deb_level);
    assign filter_inc = (r_filter_cnt < COUNT_MAX) ? (r_filter_cnt + 4'd1) : r_filter_cnt;

    always_comb begin
        n_deb_level  = r_deb_level;
        n_filter_cnt = '0;
        if (differs) begin
            if (filter_inc >= r_filter_ticks) begin
                n_deb_level  = r_in_level;
                n_filter_cnt = '0;
            end else begin
                n_filter_cnt = filter_inc;
            end
        end
    end

    // Pressed is decoded from the freshly debounced level.
    assign new_in_win = (n_deb_level >= win_lo) && (n_deb_level <= win_hi);
    assign pressed    = r_detect_mode ? new_in_win : (n_deb_level == r_active_level);

    // The tick counter runs, saturating, whenever a sequence is in progress.
    assign tick_step   = ((r_state != ST_IDLE) && (r_tick != TICK_MAX)) ? (r_tick + 1'b1) : r_tick;
    assign over_long   = 32'(tick_step) > 32'(r_long_ticks);
    assign over_short  = 32'(tick_step) > 32'(r_short_ticks);
    assign under_short = 32'(tick_step) < 32'(r_short_ticks);

    // Next state of the click machine.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (pressed) begin
                    n_state = ST_HELD;
                end
            end
            ST_HELD: begin
                if (!pressed) begin
                    n_state = ST_WAIT;
                end else if (over_long) begin
                    n_state = ST_LONG_HOLD;
                end
            end
            ST_WAIT: begin
                if (pressed) begin
                    n_state = ST_HELD_AGAIN;
                end else if (over_short) begin
                    n_state = ST_IDLE;
                end
            end
            ST_HELD_AGAIN: begin
                if (!pressed) begin
                    n_state = under_short ? ST_WAIT : ST_IDLE;
                end else if (over_short) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LONG_HOLD: begin
                if (!pressed) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Event, tick and repeat updates of the click machine.
    always_comb begin
        n_last_event = r_last_event;
        n_tick       = tick_step;
        n_repeat     = r_repeat;
        unique case (r_state)
            ST_IDLE: begin
                if (pressed) begin
                    n_last_event = EV_DOWN;
                    n_tick       = '0;
                    n_repeat     = 4'd1;
                end else begin
                    n_last_event = EV_NONE;
                end
            end
            ST_HELD: begin
                if (!pressed) begin
                    n_last_event = EV_UP;
                    n_tick       = '0;
                end else if (over_long) begin
                    n_last_event = EV_LONG_START;
                end
            end
            ST_WAIT: begin
                if (pressed) begin
                    n_last_event = EV_DOWN;
                    n_tick       = '0;
                    if (r_repeat < COUNT_MAX) begin
                        n_repeat = r_repeat + 4'd1;
                    end
                end else if (over_short) begin
                    // Runs of three or more presses leave the event as it was.
                    if (r_repeat == 4'd1) begin
                        n_last_event = EV_SINGLE;
                    end else if (r_repeat == 4'd2) begin
                        n_last_event = EV_DOUBLE;
                    end
                end
            end
            ST_HELD_AGAIN: begin
                if (!pressed) begin
                    n_last_event = EV_UP;
                    if (under_short) begin
                        n_tick = '0;
                    end
                end
            end
            ST_LONG_HOLD: begin
                n_last_event = pressed ? EV_LONG_HOLD : EV_UP;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= ST_IDLE;
            r_tick       <= '0;
            r_repeat     <= '0;
            r_deb_level  <= '0;
            r_filter_cnt <= '0;
            r_last_event <= EV_NONE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_state      <= n_state;
                r_tick       <= n_tick;
                r_repeat     <= n_repeat;
                r_deb_level  <= n_deb_level;
                r_filter_cnt <= n_filter_cnt;
                r_last_event <= n_last_event;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_level <= i_raw_level;
        end
        if (advance) begin
            r_out_event <= n_last_event;
            r_out_count <= n_repeat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out_event;
    assign o_click_count = r_out_count;

endmodule

/* rtl/core/bced_checker.sv */
// Port-level checker for the key click detector and its bind to the top level.
`timescale 1ns / 1ps
`include "button_click_event_detector_assert.svh"

module bced_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input bced_pkg::t_event       o_event_code,
    input logic [3:0]             o_click_count
);
    import bced_pkg::*;

    // Every accepted sample gives exactly one result, so a pending result
    // stays put until it is taken.
    `BCED_ASSERT_ALWAYS(a_out_hold, i_clk, i_rst_n,
        !($past(o_out_valid) && !$past(i_out_ready)) || (o_out_valid && $stable(o_event_code)
        && $stable(o_click_count)), "result changed while stalled")

    // Event codes above long hold are never produced.
    `BCED_ASSERT_ALWAYS(a_event_range, i_clk, i_rst_n,
        !o_out_valid || (o_event_code <= EV_LONG_HOLD), "event code out of range")

    // A press always belongs to a run of at least one press.
    `BCED_ASSERT_ALWAYS(a_down_count, i_clk, i_rst_n,
        !(o_out_valid && (o_event_code == EV_DOWN)) || (o_click_count != 4'd0),
        "press reported with zero click count")

    // Single and double clicks agree with the click count.
    `BCED_ASSERT_ALWAYS(a_click_count, i_clk, i_rst_n,
        !o_out_valid || ((o_event_code != EV_SINGLE || o_click_count == 4'd1)
        && (o_event_code != EV_DOUBLE || o_click_count == 4'd2)),
        "click event disagrees with click count")

    // With no result pending, a new sample is always taken.
    `BCED_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n,
        !o_out_valid |-> o_in_ready, "input stalled with empty output")

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_code  (o_event_code),
    .o_click_count (o_click_count)
);
